/* rtl/fupd_pkg.sv */
// Types, codes and character tables shared by the file URI percent decoder.
package fupd_pkg;

   localparam int unsigned SCHEME_LEN = 7;
   localparam int unsigned HOST_LEN   = 9;
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_PTR_W = 2;
   localparam int unsigned FIFO_CNT_W = 3;

   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SCHEME    = 3'd1;
   localparam logic [2:0] ST_AUTHORITY = 3'd2;
   localparam logic [2:0] ST_ESCAPE    = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef enum logic [6:0] {
      PH_PREFIX = 7'b0000001,
      PH_AFTER  = 7'b0000010,
      PH_AUTH   = 7'b0000100,
      PH_PATH   = 7'b0001000,
      PH_HEX1   = 7'b0010000,
      PH_HEX2   = 7'b0100000,
      PH_ERROR  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] uri_byte;
      logic       end_of_uri;
   } req_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] path_byte;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   // Characters of "file://"
   function automatic logic [7:0] scheme_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h66;
         4'd1:    c = 8'h69;
         4'd2:    c = 8'h6C;
         4'd3:    c = 8'h65;
         4'd4:    c = 8'h3A;
         4'd5:    c = 8'h2F;
         4'd6:    c = 8'h2F;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Characters of "localhost"
   function automatic logic [7:0] host_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h6C;
         4'd1:    c = 8'h6F;
         4'd2:    c = 8'h63;
         4'd3:    c = 8'h61;
         4'd4:    c = 8'h6C;
         4'd5:    c = 8'h68;
         4'd6:    c = 8'h6F;
         4'd7:    c = 8'h73;
         4'd8:    c = 8'h74;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Bit 4 set when the byte is a hex digit, low bits hold its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         d = {1'b1, c[3:0] + 4'd9};
      end else begin
         d = 5'd0;
      end
      return d;
   endfunction

endpackage

/* rtl/file_uri_percent_decoder_unit.sv */
// File URI checker and percent decoder with a small result queue.
//
//   channel   direction  ports                          payload
//   req       in         req_valid req_stall req_data   uri_byte, end_of_uri
//   rsp       out        rsp_valid rsp_stall rsp_data   item_kind, path_byte, status, last
//
// One byte per cycle unless stalled; its results land in a four-entry queue the next edge.
// A byte gives up to two results (path byte, then status on the last byte).
// req_stall rises when the queue has fewer than two free entries.
// Results leave one per cycle while rsp_stall is low.
// Synchronous reset returns to prefix matching and empties the queue.
module file_uri_percent_decoder_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fupd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fupd_pkg::rsp_type rsp_data
);
   import fupd_pkg::*;

   phase_type                phase_ff, phase_in;
   logic [3:0]               match_index_ff, match_index_in;
   logic [3:0]               high_nibble_ff, high_nibble_in;
   logic [2:0]               fault_code_ff, fault_code_in;

   rsp_type                  fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]    count_ff, count_in;

   logic                     req_take, rsp_take;
   logic                     emit, push0, push1;
   logic [7:0]               byte_out;
   logic [2:0]               end_status;
   logic [4:0]               hex_d;
   logic [7:0]               c;
   rsp_type                  ent0, ent1, stat_ent;

   assign c         = req_data.uri_byte;
   assign hex_d     = hex_digit(c);
   assign req_stall = count_ff > FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = count_ff != '0;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   always_comb begin
      phase_in       = phase_ff;
      match_index_in = match_index_ff;
      high_nibble_in = high_nibble_ff;
      fault_code_in  = fault_code_ff;
      emit           = 1'b0;
      byte_out       = c;
      case (phase_ff)
         PH_PREFIX: begin
            if (match_index_ff < 4'(SCHEME_LEN) && c == scheme_char(match_index_ff)) begin
               if (match_index_ff == 4'(SCHEME_LEN - 1)) begin
                  phase_in       = PH_AFTER;
                  match_index_in = '0;
               end else begin
                  match_index_in = match_index_ff + 4'd1;
               end
            end else begin
               phase_in      = PH_ERROR;
               fault_code_in = ST_SCHEME;
            end
         end
         PH_AFTER: begin
            if (c == CHAR_SLASH) begin
               phase_in = PH_PATH;
               emit     = 1'b1;
            end else if (c == host_char(4'd0)) begin
               phase_in       = PH_AUTH;
               match_index_in = 4'd1;
            end else begin
               phase_in      = PH_ERROR;
               fault_code_in = ST_AUTHORITY;
            end
         end
         PH_AUTH: begin
            if (c == CHAR_SLASH) begin
               if (match_index_ff == 4'(HOST_LEN)) begin
                  phase_in       = PH_PATH;
                  match_index_in = '0;
                  emit           = 1'b1;
               end else begin
                  phase_in      = PH_ERROR;
                  fault_code_in = ST_AUTHORITY;
               end
            end else if (match_index_ff < 4'(HOST_LEN) && c == host_char(match_index_ff)) begin
               match_index_in = match_index_ff + 4'd1;
            end else begin
               phase_in      = PH_ERROR;
               fault_code_in = ST_AUTHORITY;
            end
         end
         PH_PATH: begin
            if (c == CHAR_PERCENT) begin
               phase_in = PH_HEX1;
            end else begin
               emit = 1'b1;
            end
         end
         PH_HEX1: begin
            if (hex_d[4]) begin
               high_nibble_in = hex_d[3:0];
               phase_in       = PH_HEX2;
            end else begin
               phase_in      = PH_ERROR;
               fault_code_in = ST_ESCAPE;
            end
         end
         PH_HEX2: begin
            if (hex_d[4]) begin
               emit     = 1'b1;
               byte_out = {high_nibble_ff, hex_d[3:0]};
               phase_in = PH_PATH;
            end else begin
               phase_in      = PH_ERROR;
               fault_code_in = ST_ESCAPE;
            end
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      // Status is taken from the phase after this byte
      case (phase_in)
         PH_PREFIX: end_status = ST_SCHEME;
         PH_AFTER:  end_status = ST_EMPTY;
         PH_AUTH:   end_status = ST_AUTHORITY;
         PH_PATH:   end_status = ST_OK;
         PH_HEX1:   end_status = ST_ESCAPE;
         PH_HEX2:   end_status = ST_ESCAPE;
         default:   end_status = fault_code_in;
      endcase

      // Drop back to the start for the next URI
      if (req_data.end_of_uri) begin
         phase_in       = PH_PREFIX;
         match_index_in = '0;
         high_nibble_in = '0;
         fault_code_in  = ST_OK;
      end
   end

   always_comb begin
      stat_ent.item_kind = KIND_STATUS;
      stat_ent.path_byte = '0;
      stat_ent.status    = end_status;
      stat_ent.last      = 1'b1;

      ent1 = stat_ent;
      if (emit) begin
         ent0.item_kind = KIND_BYTE;
         ent0.path_byte = byte_out;
         ent0.status    = ST_OK;
         ent0.last      = 1'b0;
      end else begin
         ent0 = stat_ent;
      end

      push0     = req_take && (emit || req_data.end_of_uri);
      push1     = req_take && emit && req_data.end_of_uri;
      wr_ptr_nx = wr_ptr_ff + FIFO_PTR_W'(1);

      wr_ptr_in = wr_ptr_ff;
      if (push1) begin
         wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(2);
      end else if (push0) begin
         wr_ptr_in = wr_ptr_nx;
      end
      rd_ptr_in = rsp_take ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1)
                  - FIFO_CNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_PREFIX;
         match_index_ff <= '0;
         high_nibble_ff <= '0;
         fault_code_ff  <= ST_OK;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         if (req_take) begin
            phase_ff       <= phase_in;
            match_index_ff <= match_index_in;
            high_nibble_ff <= high_nibble_in;
            fault_code_ff  <= fault_code_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         fifo_ff[wr_ptr_ff] <= ent0;
      end
      if (push1) begin
         fifo_ff[wr_ptr_nx] <= ent1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      req_take && req_data.end_of_uri |=> phase_ff == PH_PREFIX && fault_code_ff == ST_OK)
      else $error("last transaction did not restart the parser");

   a_error_coded: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |-> fault_code_ff != ST_OK)
      else $error("error phase without fault code");

   a_room_for_two: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2))
      else $error("accepting without room for two results");

endmodule

/* bench/uri_decode_checker.sv */
// Scoreboard for the file URI decoder: predicts results of accepted bytes and checks them.
`timescale 1ns / 100ps
module uri_decode_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  fupd_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  fupd_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                outstanding
);
   import fupd_pkg::*;

   localparam logic [8*SCHEME_LEN-1:0] SCHEME_TEXT = "file://";
   localparam logic [8*HOST_LEN-1:0]   HOST_TEXT   = "localhost";
   localparam int                      REPORT_MAX  = 10;

   phase_type  phase;
   logic [3:0] match_index;
   logic [3:0] high_nibble;
   logic [2:0] fault_code;
   rsp_type    expected_q[$];
   int         fail_count = 0;

   function automatic logic [7:0] host_char(input logic [3:0] idx);
      if (idx >= HOST_LEN) begin
         return 8'h00;
      end
      return HOST_TEXT[8*(HOST_LEN-1-idx) +: 8];
   endfunction

   // Bit 4 flags a hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      logic       ok;
      ok = 1'b1;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         ok = 1'b0;
         v  = 8'h00;
      end
      return {ok, v[3:0]};
   endfunction

   task automatic reset_decoder();
      phase       = PH_PREFIX;
      match_index = 4'd0;
      high_nibble = 4'd0;
      fault_code  = ST_OK;
   endtask

   task automatic fail_with(input logic [2:0] code);
      phase      = PH_ERROR;
      fault_code = code;
   endtask

   task automatic push_result(input logic kind, input logic [7:0] b, input logic [2:0] st);
      rsp_type r;
      r.item_kind = kind;
      r.path_byte = b;
      r.status    = st;
      r.last      = kind;
      expected_q  = {expected_q, r};
   endtask

   task automatic decode_byte(input req_type t);
      logic       emit;
      logic [7:0] c;
      logic [7:0] out_byte;
      logic [4:0] nib;
      logic [2:0] code;
      c        = t.uri_byte;
      emit     = 1'b0;
      out_byte = c;
      nib      = hex_nibble(c);
      case (phase)
         PH_PREFIX: begin
            if (c == SCHEME_TEXT[8*(SCHEME_LEN-1-match_index) +: 8]) begin
               match_index = match_index + 4'd1;
               if (match_index == SCHEME_LEN) begin
                  phase       = PH_AFTER;
                  match_index = 4'd0;
               end
            end else begin
               fail_with(ST_SCHEME);
            end
         end
         PH_AFTER: begin
            if (c == CHAR_SLASH) begin
               phase = PH_PATH;
               emit  = 1'b1;
            end else if (c == host_char(4'd0)) begin
               phase       = PH_AUTH;
               match_index = 4'd1;
            end else begin
               fail_with(ST_AUTHORITY);
            end
         end
         PH_AUTH: begin
            if (c == CHAR_SLASH) begin
               if (match_index == HOST_LEN) begin
                  phase       = PH_PATH;
                  match_index = 4'd0;
                  emit        = 1'b1;
               end else begin
                  fail_with(ST_AUTHORITY);
               end
            end else if (match_index < HOST_LEN && c == host_char(match_index)) begin
               match_index = match_index + 4'd1;
            end else begin
               fail_with(ST_AUTHORITY);
            end
         end
         PH_PATH: begin
            if (c == CHAR_PERCENT) begin
               phase = PH_HEX1;
            end else begin
               emit = 1'b1;
            end
         end
         PH_HEX1: begin
            if (nib[4]) begin
               high_nibble = nib[3:0];
               phase       = PH_HEX2;
            end else begin
               fail_with(ST_ESCAPE);
            end
         end
         PH_HEX2: begin
            if (nib[4]) begin
               emit     = 1'b1;
               out_byte = {high_nibble, nib[3:0]};
               phase    = PH_PATH;
            end else begin
               fail_with(ST_ESCAPE);
            end
         end
         default: begin
            phase = PH_ERROR;
         end
      endcase

      if (emit) begin
         push_result(KIND_BYTE, out_byte, ST_OK);
      end

      if (t.end_of_uri) begin
         case (phase)
            PH_PREFIX:        code = ST_SCHEME;
            PH_AFTER:         code = ST_EMPTY;
            PH_AUTH:          code = ST_AUTHORITY;
            PH_PATH:          code = ST_OK;
            PH_HEX1, PH_HEX2: code = ST_ESCAPE;
            default:          code = fault_code;
         endcase
         push_result(KIND_STATUS, 8'h00, code);
         reset_decoder();
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         reset_decoder();
         expected_q.delete();
      end else begin
         // Results trail their byte through the registered queue: check before predicting.
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("%0t: unexpected transaction kind %0d byte %02h status %0d last %0d",
                           $realtime, rsp_data.item_kind, rsp_data.path_byte,
                           rsp_data.status, rsp_data.last);
               end
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.item_kind !== want.item_kind ||
                   rsp_data.path_byte !== want.path_byte ||
                   rsp_data.status !== want.status ||
                   rsp_data.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display("%0t: mismatch: expected kind %0d byte %02h status %0d last %0d",
                              $realtime, want.item_kind, want.path_byte, want.status,
                              want.last);
                     $display("%0t:            actual kind %0d byte %02h status %0d last %0d",
                              $realtime, rsp_data.item_kind, rsp_data.path_byte,
                              rsp_data.status, rsp_data.last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_data);
         end
      end
      mismatches  <= fail_count;
      outstanding <= expected_q.size();
   end

endmodule

/* bench/tb.sv */
// Top of the file URI decoder bench: clock, reset, URI stimulus and the verdict.
`timescale 1ns / 100ps
module tb;
   import fupd_pkg::*;

   localparam int RANDOM_BYTES = 1350;
   localparam int CALM_BYTES   = 1150;
   localparam int IDLE_LIMIT   = 200;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       calm;
   int         mismatches;
   int         outstanding;
   int         byte_count;
   logic [7:0] uri_bytes[$];

   file_uri_percent_decoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   uri_decode_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
      if (v < 4'd10) begin
         return 8'h30 + v;
      end
      return (upper ? 8'h41 : 8'h61) + v - 8'd10;
   endfunction

   task automatic add_byte(input logic [7:0] b);
      uri_bytes = {uri_bytes, b};
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i]);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eou);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{uri_byte: b, end_of_uri: eou};
      do @(posedge clock); while (req_stall);
      byte_count++;
   endtask

   task automatic send_uri();
      for (int i = 0; i < uri_bytes.size(); i++) begin
         send_byte(uri_bytes[i], i == uri_bytes.size() - 1);
      end
   endtask

   // Hold the sender until every predicted transaction has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic make_uri();
      int         mode;
      int         n;
      int         pos;
      logic [7:0] c;
      uri_bytes.delete();
      mode = $urandom_range(0, 9);
      if (mode == 9) begin
         // raw noise, sometimes behind a good prefix
         if ($urandom_range(0, 1) == 1) begin
            add_text("file://");
         end
         n = $urandom_range(1, 10);
         repeat (n) add_byte(8'($urandom));
      end else begin
         add_text("file://");
         if (mode == 8) begin
            case ($urandom_range(0, 3))
               0:       add_text("localhos");
               1:       add_text("localhostt");
               2:       add_text("localhast");
               default: add_byte(8'($urandom));
            endcase
         end else if ($urandom_range(0, 1) == 1) begin
            add_text("localhost");
         end
         add_byte(CHAR_SLASH);
         n   = $urandom_range(0, 12);
         pos = (mode == 6) ? $urandom_range(0, n) : -1;
         for (int k = 0; k <= n; k++) begin
            if (k == pos) begin
               add_byte(CHAR_PERCENT);
               if ($urandom_range(0, 1) == 1) begin
                  add_byte(hex_char(4'($urandom), 1'($urandom)));
               end
               c = 8'($urandom);
               if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                   (c >= 8'h61 && c <= 8'h66)) begin
                  c = 8'h67;
               end
               add_byte(c);
            end else if (k < n) begin
               if ($urandom_range(0, 3) == 0) begin
                  add_byte(CHAR_PERCENT);
                  add_byte(hex_char(4'($urandom), 1'($urandom)));
                  add_byte(hex_char(4'($urandom), 1'($urandom)));
               end else begin
                  c = 8'($urandom);
                  if (c == CHAR_PERCENT) begin
                     c = 8'hA5;
                  end
                  add_byte(c);
               end
            end
         end
         if (mode == 5) begin
            pos = $urandom_range(0, uri_bytes.size() - 1);
            uri_bytes[pos] = 8'($urandom);
         end else if (mode == 7) begin
            n = $urandom_range(1, uri_bytes.size());
            while (uri_bytes.size() > n) begin
               void'(uri_bytes.pop_back());
            end
         end
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin : rsp_idle
         int hold;
         hold = 0;
         forever begin
            @(posedge clock);
            if (hold > 0) begin
               hold--;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
               hold = $urandom_range(1, 3);
            end
            rsp_stall <= (hold > 0);
         end
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      logic paused;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      calm       = 1'b0;
      byte_count = 0;
      paused     = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // lone extreme bytes, bare prefix, and a mixed-case escape
      uri_bytes = {8'h00};
      send_uri();
      uri_bytes = {8'hFF};
      send_uri();
      uri_bytes.delete();
      add_text("file://");
      send_uri();
      uri_bytes.delete();
      add_text("file:///%aF");
      send_uri();
      drain();

      byte_count = 0;
      while (byte_count < RANDOM_BYTES) begin
         make_uri();
         send_uri();
         if (byte_count >= CALM_BYTES) begin
            calm <= 1'b1;
         end
         if (!paused && byte_count >= RANDOM_BYTES / 2) begin
            drain();
            paused = 1'b1;
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
